@@ rtl/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg
// Opcodes, status codes and shared constants of the fixed-point ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

	// quotient bits resolved per divider stage
	localparam int DIV_BPS = 4;

	typedef enum logic [3:0] {
		OP_ADD     = 4'd0,
		OP_SUB     = 4'd1,
		OP_MUL     = 4'd2,
		OP_DIV     = 4'd3,
		OP_GT      = 4'd4,
		OP_LT      = 4'd5,
		OP_GE      = 4'd6,
		OP_LE      = 4'd7,
		OP_EQ      = 4'd8,
		OP_NE      = 4'd9,
		OP_INC     = 4'd10,
		OP_DEC     = 4'd11,
		OP_MIN     = 4'd12,
		OP_MAX     = 4'd13,
		OP_TOINT   = 4'd14,
		OP_FROMINT = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIV0 = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	typedef struct packed {
		logic is_mul;
		logic is_div;
		logic neg;
		logic dz;
		logic cmp;
	} ctl_t;

endpackage

`default_nettype wire

@@ rtl/fixed_point_alu_q24_8.sv @@
// Throughput: one request per cycle unless the output stalls; 4 quotient bits per divider stage.
// A stall at the output freezes every stage; nothing is dropped or repeated.
// Reset clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Signed fixed-point ALU: add, sub, rounded mul and div, compares, inc, dec,
// min, max and integer conversions, with saturation and status.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu_q24_8 #(
	parameter int FRACTION_BITS = 8,
	parameter int WORD_BITS = 32
) (
	input wire clk,
	input wire arst_n,
	input wire s_tvalid,
	output logic s_tready,
	input wire [63:0] s_tdata,   // left_value[31:0], right_value[63:32]
	input wire [3:0] s_tuser,    // kind[3:0]
	output logic m_tvalid,
	input wire m_tready,
	output logic [39:0] m_tdata  // result_value[31:0], compare_true[32], status[34:33], zero
);

	localparam int RW = (WORD_BITS > 32) ? 32 : ((WORD_BITS < 2) ? 2 : WORD_BITS);
	localparam int FB = FRACTION_BITS;
	localparam int PW = 2 * RW;
	localparam int WW = 2 * RW + FB + 2;
	localparam int DST = (RW + FB + fpa_pkg::DIV_BPS - 1) / fpa_pkg::DIV_BPS;
	localparam int DNP = DST * fpa_pkg::DIV_BPS;
	localparam int DLY = DST - 3;
	localparam int LAT = DST + 3;
	localparam logic [PW-1:0] MUL_HALF = (PW'(1) << FB) >> 1;
	localparam logic signed [WW-1:0] SAT_HI = (WW'(1) << (RW - 1)) - WW'(1);
	localparam logic signed [WW-1:0] SAT_LO = ~SAT_HI;

	// ---------------- pipeline control ----------------
	logic adv;
	logic [LAT-1:0] vld_q;

	assign adv = !vld_q[LAT-1] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// ---------------- stage 1: operand decode ----------------
	logic signed [RW-1:0] a_in, b_in;
	logic [RW-1:0] amag_in, bmag_in;

	assign a_in = s_tdata[RW-1:0];
	assign b_in = s_tdata[32+RW-1:32];
	assign amag_in = a_in[RW-1] ? RW'(~a_in + 1'b1) : a_in;
	assign bmag_in = b_in[RW-1] ? RW'(~b_in + 1'b1) : b_in;

	fpa_pkg::op_t kind_s1;
	logic signed [RW-1:0] a_s1, b_s1;
	logic [RW-1:0] amag_s1, bmag_s1;
	logic neg_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= fpa_pkg::op_t'(s_tuser);
			a_s1 <= a_in;
			b_s1 <= b_in;
			amag_s1 <= amag_in;
			bmag_s1 <= bmag_in;
			neg_s1 <= a_in[RW-1] ^ b_in[RW-1];
		end
	end

	// ---------------- divider ----------------
	logic [DNP-1:0] div_quo;
	logic [RW-1:0] div_rem, div_den;

	fpa_div #(
		.MW(RW),
		.FB(FB)
	) u_div (
		.clk(clk),
		.en(adv),
		.num(amag_s1),
		.den(bmag_s1),
		.quo(div_quo),
		.rem(div_rem),
		.den_out(div_den)
	);

	// ---------------- stage 2: simple ops, product ----------------
	logic signed [WW-1:0] a_w, b_w, val_c;
	fpa_pkg::ctl_t ctl_c;
	logic gt, lt, eq;

	assign a_w = WW'(a_s1);
	assign b_w = WW'(b_s1);
	assign gt = a_s1 > b_s1;
	assign lt = a_s1 < b_s1;
	assign eq = a_s1 == b_s1;

	always_comb begin
		val_c = '0;
		ctl_c.is_mul = 1'b0;
		ctl_c.is_div = 1'b0;
		ctl_c.neg = neg_s1;
		ctl_c.dz = (b_s1 == '0);
		ctl_c.cmp = 1'b0;
		case (kind_s1)
			fpa_pkg::OP_ADD: val_c = a_w + b_w;
			fpa_pkg::OP_SUB: val_c = a_w - b_w;
			fpa_pkg::OP_MUL: ctl_c.is_mul = 1'b1;
			fpa_pkg::OP_DIV: ctl_c.is_div = 1'b1;
			fpa_pkg::OP_GT: ctl_c.cmp = gt;
			fpa_pkg::OP_LT: ctl_c.cmp = lt;
			fpa_pkg::OP_GE: ctl_c.cmp = !lt;
			fpa_pkg::OP_LE: ctl_c.cmp = !gt;
			fpa_pkg::OP_EQ: ctl_c.cmp = eq;
			fpa_pkg::OP_NE: ctl_c.cmp = !eq;
			fpa_pkg::OP_INC: val_c = a_w + WW'(1);
			fpa_pkg::OP_DEC: val_c = a_w - WW'(1);
			fpa_pkg::OP_MIN: val_c = gt ? b_w : a_w;
			fpa_pkg::OP_MAX: val_c = gt ? a_w : b_w;
			fpa_pkg::OP_TOINT: val_c = WW'(a_s1 >>> FB);
			fpa_pkg::OP_FROMINT: val_c = a_w <<< FB;
			default: val_c = '0;
		endcase
	end

	logic signed [WW-1:0] val_s2;
	fpa_pkg::ctl_t ctl_s2;
	logic [PW-1:0] pm_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			val_s2 <= val_c;
			ctl_s2 <= ctl_c;
			pm_s2 <= PW'(amag_s1) * PW'(bmag_s1);
		end
	end

	// ---------------- stage 3: round product ----------------
	logic signed [WW-1:0] val_s3;
	fpa_pkg::ctl_t ctl_s3;
	logic [PW-1:0] pr_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			val_s3 <= val_s2;
			ctl_s3 <= ctl_s2;
			pr_s3 <= (pm_s2 + MUL_HALF) >> FB;
		end
	end

	// ---------------- stage 4: sign product ----------------
	logic signed [WW-1:0] mul_w;
	logic signed [WW-1:0] val_s4;
	fpa_pkg::ctl_t ctl_s4;

	assign mul_w = WW'(pr_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			val_s4 <= ctl_s3.is_mul ? (ctl_s3.neg ? -mul_w : mul_w) : val_s3;
			ctl_s4 <= ctl_s3;
		end
	end

	// hold side results until the quotient leaves the divider
	logic signed [WW-1:0] val_dly_s [0:DLY-1];
	fpa_pkg::ctl_t ctl_dly_s [0:DLY-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			val_dly_s[0] <= val_s4;
			ctl_dly_s[0] <= ctl_s4;
			for (int i = 1; i < DLY; i++) begin
				val_dly_s[i] <= val_dly_s[i-1];
				ctl_dly_s[i] <= ctl_dly_s[i-1];
			end
		end
	end

	// ---------------- round stage: quotient rounding and sign ----------------
	logic div_rnd, div_neg;
	logic signed [WW-1:0] div_w;
	logic signed [WW-1:0] val_sr;
	fpa_pkg::ctl_t ctl_sr;

	assign div_neg = ctl_dly_s[DLY-1].neg;
	assign div_rnd = {div_rem, 1'b0} >= {1'b0, div_den};
	// -(q + r) folds into ~q + !r, so one adder serves both signs
	assign div_w = (WW'(div_quo) ^ {WW{div_neg}}) + WW'(div_rnd ^ div_neg);

	always_ff @(posedge clk) begin
		if (adv) begin
			val_sr <= ctl_dly_s[DLY-1].is_div ? div_w : val_dly_s[DLY-1];
			ctl_sr <= ctl_dly_s[DLY-1];
		end
	end

	// ---------------- output stage: divide by zero, saturate ----------------
	logic signed [RW-1:0] res_c;
	fpa_pkg::status_t st_c;
	logic signed [RW-1:0] res_so;
	fpa_pkg::status_t st_so;
	logic cmp_so;

	always_comb begin
		res_c = val_sr[RW-1:0];
		st_c = fpa_pkg::ST_OK;
		if (ctl_sr.is_div && ctl_sr.dz) begin
			res_c = '0;
			st_c = fpa_pkg::ST_DIV0;
		end else if (val_sr > SAT_HI) begin
			res_c = SAT_HI[RW-1:0];
			st_c = fpa_pkg::ST_OVF;
		end else if (val_sr < SAT_LO) begin
			res_c = SAT_LO[RW-1:0];
			st_c = fpa_pkg::ST_OVF;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_so <= res_c;
			st_so <= st_c;
			cmp_so <= ctl_sr.cmp;
		end
	end

	assign m_tdata = {5'b0, st_so, cmp_so, 32'(res_so)};

	// ---------------- assertions ----------------
	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st_so == fpa_pkg::ST_DIV0 |-> res_so == '0 && !cmp_so)
		else $error("divide by zero result not cleared");

	a_cmp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && cmp_so |-> st_so == fpa_pkg::ST_OK && res_so == '0)
		else $error("compare result carries value or status");

	a_ovf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st_so == fpa_pkg::ST_OVF |->
			res_so == SAT_HI[RW-1:0] || res_so == SAT_LO[RW-1:0])
		else $error("overflow status without saturated result");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[0])
		else $error("accepted request not tracked in first stage");

endmodule

`default_nettype wire

@@ rtl/fpa_div.sv @@
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider: (num << FB) / den on unsigned magnitudes,
// DIV_BPS quotient bits per stage, one division accepted per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_div #(
	parameter int MW = 32,
	parameter int FB = 8,
	localparam int STAGES = (MW + FB + fpa_pkg::DIV_BPS - 1) / fpa_pkg::DIV_BPS,
	localparam int NP = STAGES * fpa_pkg::DIV_BPS
) (
	input wire clk,
	input wire en,
	input wire [MW-1:0] num,
	input wire [MW-1:0] den,
	output logic [NP-1:0] quo,
	output logic [MW-1:0] rem,
	output logic [MW-1:0] den_out
);

	logic [MW-1:0] rem_s [1:STAGES];
	logic [NP-1:0] nq_s [1:STAGES];
	logic [MW-1:0] den_s [1:STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [MW-1:0] rem_in;
		logic [NP-1:0] nq_in;
		logic [MW-1:0] den_in;
		logic [MW-1:0] rem_nx;
		logic [NP-1:0] nq_nx;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in = NP'(num) << FB;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[k];
			assign nq_in = nq_s[k];
			assign den_in = den_s[k];
		end

		// numerator shifts out the top, quotient bits shift in at the bottom
		always_comb begin
			logic [MW:0] sh;
			rem_nx = rem_in;
			nq_nx = nq_in;
			for (int i = 0; i < fpa_pkg::DIV_BPS; i++) begin
				sh = {rem_nx, nq_nx[NP-1]};
				if (sh >= {1'b0, den_in}) begin
					rem_nx = MW'(sh - {1'b0, den_in});
					nq_nx = {nq_nx[NP-2:0], 1'b1};
				end else begin
					rem_nx = sh[MW-1:0];
					nq_nx = {nq_nx[NP-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= rem_nx;
				nq_s[k+1] <= nq_nx;
				den_s[k+1] <= den_in;
			end
		end
	end

	assign quo = nq_s[STAGES];
	assign rem = rem_s[STAGES];
	assign den_out = den_s[STAGES];

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Q24.8 fixed-point ALU. A directed burst hits
// the saturation bounds, rounding ties, divide by zero and every compare;
// random requests follow under several idle and backpressure mixes. Each
// accepted request is predicted in integer math and checked in order.
// ----------------------------------------------------------------------------

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 8;
	localparam int LATENCY = 13;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_PER_PHASE = 412;
	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [31:0] value;
		logic flag;
		fpa_pkg::status_t st;
	} alu_outcome_t;

	class alu_scoreboard;
		alu_outcome_t pending_outcomes[$];
		int failures;

		function new();
			failures = 0;
		endfunction

		function automatic longint clamp_word(input longint x,
				inout fpa_pkg::status_t st);
			if (x > WORD_MAX) begin
				st = fpa_pkg::ST_OVF;
				return WORD_MAX;
			end
			if (x < WORD_MIN) begin
				st = fpa_pkg::ST_OVF;
				return WORD_MIN;
			end
			return x;
		endfunction

		function automatic alu_outcome_t compute_outcome(input fpa_pkg::op_t op,
				input logic [31:0] lv, input logic [31:0] rv);
			longint a, b, r;
			longint unsigned ma, mb, q;
			logic neg;
			alu_outcome_t o;
			a = longint'($signed(lv));
			b = longint'($signed(rv));
			ma = longint'(a < 0 ? -a : a);
			mb = longint'(b < 0 ? -b : b);
			neg = (a < 0) != (b < 0);
			r = 0;
			o.flag = 1'b0;
			o.st = fpa_pkg::ST_OK;
			case (op)
				fpa_pkg::OP_ADD: r = clamp_word(a + b, o.st);
				fpa_pkg::OP_SUB: r = clamp_word(a - b, o.st);
				fpa_pkg::OP_MUL: begin
					// round the magnitude half away from zero, then restore the sign
					q = (ma * mb + (64'd1 << (FRAC - 1))) >> FRAC;
					r = clamp_word(neg ? -longint'(q) : longint'(q), o.st);
				end
				fpa_pkg::OP_DIV: begin
					if (b == 0) begin
						o.st = fpa_pkg::ST_DIV0;
					end else begin
						q = (2 * (ma << FRAC) + mb) / (2 * mb);
						r = clamp_word(neg ? -longint'(q) : longint'(q), o.st);
					end
				end
				fpa_pkg::OP_GT: o.flag = a > b;
				fpa_pkg::OP_LT: o.flag = a < b;
				fpa_pkg::OP_GE: o.flag = a >= b;
				fpa_pkg::OP_LE: o.flag = a <= b;
				fpa_pkg::OP_EQ: o.flag = a == b;
				fpa_pkg::OP_NE: o.flag = a != b;
				fpa_pkg::OP_INC: r = clamp_word(a + 1, o.st);
				fpa_pkg::OP_DEC: r = clamp_word(a - 1, o.st);
				fpa_pkg::OP_MIN: r = (a > b) ? b : a;
				fpa_pkg::OP_MAX: r = (a > b) ? a : b;
				fpa_pkg::OP_TOINT: r = a >>> FRAC;
				default: r = clamp_word(a * (64'sd1 << FRAC), o.st);
			endcase
			o.value = r[31:0];
			return o;
		endfunction

		function void note_request(input fpa_pkg::op_t op, input logic [31:0] lv,
				input logic [31:0] rv);
			pending_outcomes.push_back(compute_outcome(op, lv, rv));
		endfunction

		task report(input string what, input logic [31:0] got, input logic [31:0] expv);
			$display("%0t ns mismatch on %s: got %h, expected %h", $time, what, got, expv);
			failures++;
		endtask

		task check_result(input logic [39:0] data);
			alu_outcome_t expv;
			if (pending_outcomes.size() == 0) begin
				report("unrequested result", data[31:0], 32'd0);
			end else begin
				expv = pending_outcomes.pop_front();
				if (data[31:0] !== expv.value)
					report("result_value", data[31:0], expv.value);
				if (data[32] !== expv.flag)
					report("compare_true", 32'(data[32]), 32'(expv.flag));
				if (data[34:33] !== expv.st)
					report("status", 32'(data[34:33]), 32'(expv.st));
			end
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;  // left_value[31:0], right_value[63:32]
	logic [3:0] s_tuser = '0;   // kind[3:0]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;       // result_value[31:0], compare_true[32], status[34:33], zero

	int send_idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	alu_scoreboard sb = new();

	fixed_point_alu_q24_8 #(
		.FRACTION_BITS(FRAC),
		.WORD_BITS(32)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_request(fpa_pkg::op_t'(s_tuser), s_tdata[31:0], s_tdata[63:32]);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// bias toward word bounds, zero, whole numbers and the multiply overflow edge
	function automatic logic [31:0] pick_operand();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: v = 32'h7fffffff - $urandom_range(0, 3);
			1: v = 32'h80000000 + $urandom_range(0, 3);
			2: v = 32'($urandom_range(0, 1023)) - 32'd512;
			3: v = '0;
			4: v = 32'($urandom_range(0, 65535)) << FRAC;
			5: v = 32'($urandom_range(0, 1 << 21));
			default: v = $urandom();
		endcase
		if (($urandom_range(0, 9) inside {4, 5}) && $urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	task automatic send_request(input fpa_pkg::op_t op, input logic [31:0] lv,
			input logic [31:0] rv);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {rv, lv};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	initial begin
		int send_pcts[4];
		int stall_pcts[4];
		int ph;
		send_pcts = '{0, 57, 0, 32};
		stall_pcts = '{0, 0, 57, 32};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// saturation at both bounds
		send_request(fpa_pkg::OP_ADD, 32'h7fffffff, 32'h00000001);
		send_request(fpa_pkg::OP_ADD, 32'h80000000, 32'hffffffff);
		send_request(fpa_pkg::OP_SUB, 32'h80000000, 32'h00000001);
		send_request(fpa_pkg::OP_SUB, 32'h7fffffff, 32'h80000000);
		send_request(fpa_pkg::OP_MUL, 32'h7fffffff, 32'h7fffffff);
		send_request(fpa_pkg::OP_MUL, 32'h80000000, 32'h80000000);
		// rounding ties go away from zero
		send_request(fpa_pkg::OP_MUL, 32'h00000001, 32'h00000080);
		send_request(fpa_pkg::OP_MUL, 32'hffffffff, 32'h00000080);
		send_request(fpa_pkg::OP_MUL, 32'h00000180, 32'hfffffe80);
		send_request(fpa_pkg::OP_DIV, 32'h00000100, 32'h00000000);
		send_request(fpa_pkg::OP_DIV, 32'h80000000, 32'hffffffff);
		send_request(fpa_pkg::OP_DIV, 32'h00000001, 32'h00000200);
		send_request(fpa_pkg::OP_DIV, 32'hffffffff, 32'h00000200);
		send_request(fpa_pkg::OP_DIV, 32'h00000100, 32'h00000300);
		send_request(fpa_pkg::OP_GT, 32'h7fffffff, 32'h80000000);
		send_request(fpa_pkg::OP_LT, 32'h80000000, 32'h7fffffff);
		send_request(fpa_pkg::OP_GE, 32'h00000005, 32'h00000005);
		send_request(fpa_pkg::OP_LE, 32'h80000000, 32'h80000000);
		send_request(fpa_pkg::OP_EQ, 32'h00000000, 32'h00000000);
		send_request(fpa_pkg::OP_NE, 32'hffffffff, 32'h7fffffff);
		send_request(fpa_pkg::OP_INC, 32'h7fffffff, 32'h00000000);
		send_request(fpa_pkg::OP_DEC, 32'h80000000, 32'h00000000);
		// equal operands pick left for min, right for max; only the min request here has equal operands
		send_request(fpa_pkg::OP_MIN, 32'h00000100, 32'h00000100);
		send_request(fpa_pkg::OP_MAX, 32'h80000000, 32'h7fffffff);
		send_request(fpa_pkg::OP_TOINT, 32'hffffffff, 32'h00000000);
		send_request(fpa_pkg::OP_TOINT, 32'h80000000, 32'h00000000);
		send_request(fpa_pkg::OP_FROMINT, 32'h7fffffff, 32'h00000000);
		send_request(fpa_pkg::OP_FROMINT, 32'h80000000, 32'h00000000);

		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_pcts[ph];
			stall_pct = stall_pcts[ph];
			repeat (RANDOM_PER_PHASE)
				send_request(fpa_pkg::op_t'($urandom_range(0, 15)), pick_operand(),
					pick_operand());
		end
		s_tvalid <= 1'b0;

		// drain, then keep clocking to catch stray results
		while (sb.pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (3 * LATENCY) @(posedge clk);

		if (sb.failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
